@@ sv/char_sequence_store_assert.svh @@
// Assertion macros shared by the char_sequence_store RTL.
`ifndef CHAR_SEQUENCE_STORE_ASSERT_SVH
`define CHAR_SEQUENCE_STORE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, and off while i_rst_n is low.
`define CSQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("char_sequence_store assertion failed");

// Next-cycle implication, clocked on i_clk, and off while i_rst_n is low.
`define CSQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("char_sequence_store assertion failed");

`endif

@@ sv/csq_pkg.sv @@
// Shared constants, types and slot arithmetic for the char sequence store.
`default_nettype none
package csq_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CHAR_W = 8;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  position;
        logic [CNT_W-1:0]  removed;
        logic [CNT_W-1:0]  length;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Next slot of the circular store.
    function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] s);
        logic [ADDR_W-1:0] r;
        if (s == ADDR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    // Previous slot of the circular store.
    function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] s);
        logic [ADDR_W-1:0] r;
        if (s == '0) begin
            r = ADDR_W'(DEPTH - 1);
        end else begin
            r = s - 1'b1;
        end
        return r;
    endfunction

    // Slot that lies n entries after slot s; n never exceeds DEPTH.
    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] s,
                                                  input logic [CNT_W-1:0]  n);
        logic [ADDR_W:0] sum;
        logic [ADDR_W:0] r;
        sum = {1'b0, s} + (ADDR_W+1)'(n);
        if (sum >= (ADDR_W+1)'(DEPTH)) begin
            r = sum - (ADDR_W+1)'(DEPTH);
        end else begin
            r = sum;
        end
        return r[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/char_sequence_store.sv @@
// Top level of the char sequence store: entry memory, sequencer and result register.
//
//  Channel   Direction  Handshake            Payload
//  command   in         i_valid / o_stall    i_command, i_first_char, i_second_char
//  result    out        o_valid / i_stall    o_status, o_position, o_removed_count, o_length
//
// Insert, append, clear and unused codes finish without a scan. On a non-empty sequence,
// remove scans every entry and find scans until its first match (every entry on a miss);
// on an empty one neither scans. The scan walks the entry memory through its single read
// port, one entry per cycle.
// Reset (synchronous, active low) empties the sequence; memory contents are not cleared.
// A stalled result waits in the output register while the next request is already taken.
`default_nettype none
module char_sequence_store import csq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [CHAR_W-1:0] i_first_char,
    input  wire logic [CHAR_W-1:0] i_second_char,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [STAT_W-1:0]      o_status,
    output logic [CNT_W-1:0]       o_position,
    output logic [CNT_W-1:0]       o_removed_count,
    output logic [CNT_W-1:0]       o_length
);

    t_ram_req          ram;
    logic [CHAR_W-1:0] rd_data;
    logic              res_valid;
    logic              res_take;
    t_result           res;
    logic              r_out_valid;
    t_result           r_out;

    // The entry memory holds the sequence as a circular buffer that starts at the head slot.
    csq_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram.we),
        .i_waddr(ram.waddr),
        .i_wdata(ram.wdata),
        .i_raddr(ram.raddr),
        .o_rdata(rd_data)
    );

    // The sequencer accepts one request at a time and returns to idle once its result
    // has moved into the output register.
    csq_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_first_char (i_first_char),
        .i_second_char(i_second_char),
        .o_ram        (ram),
        .i_rd_data    (rd_data),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res)
    );

    // The output register loads when it is empty or its current result leaves this cycle.
    assign res_take = res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_position      = r_out.position;
    assign o_removed_count = r_out.removed;
    assign o_length        = r_out.length;

endmodule
`default_nettype wire

@@ sv/csq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module csq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/csq_engine.sv @@
// Command sequencer: runs each request against the entry memory and builds its result.
`default_nettype none
`include "char_sequence_store_assert.svh"
module csq_engine import csq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [CHAR_W-1:0] i_first_char,
    input  wire logic [CHAR_W-1:0] i_second_char,
    output t_ram_req               o_ram,
    input  wire logic [CHAR_W-1:0] i_rd_data,
    output logic                   o_res_valid,
    input  wire logic              i_res_take,
    output t_result                o_res
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [CHAR_W-1:0] r_a, n_a;
    logic [CHAR_W-1:0] r_b, n_b;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic [ADDR_W-1:0] r_rd_slot, n_rd_slot;
    logic [CNT_W-1:0]  r_kept, n_kept;
    logic [ADDR_W-1:0] r_kept_slot, n_kept_slot;
    logic              r_chk_valid, n_chk_valid;
    t_result           r_res, n_res;
    logic              rd_issue;
    logic              full;
    logic [CNT_W-1:0]  kept_next;

    assign full        = (r_count == CNT_W'(DEPTH));
    assign o_stall     = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_cmd       = r_cmd;
        n_a         = r_a;
        n_b         = r_b;
        n_rd_idx    = r_rd_idx;
        n_rd_slot   = r_rd_slot;
        n_kept      = r_kept;
        n_kept_slot = r_kept_slot;
        n_chk_valid = 1'b0;
        n_res       = r_res;
        rd_issue    = 1'b0;
        kept_next   = r_kept;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_kept_slot;
        o_ram.wdata = i_rd_data;
        o_ram.raddr = r_rd_slot;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd       = i_command;
                    n_a         = i_first_char;
                    n_b         = i_second_char;
                    n_rd_idx    = '0;
                    n_rd_slot   = r_head;
                    n_kept      = '0;
                    n_kept_slot = r_head;
                    n_res.status   = STAT_OK;
                    n_res.position = '0;
                    n_res.removed  = '0;
                    n_res.length   = r_count;
                    n_state        = ST_DONE;
                    unique case (i_command)
                        CMD_INSERT: begin
                            if (full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                o_ram.we     = 1'b1;
                                o_ram.waddr  = slot_dec(r_head);
                                o_ram.wdata  = i_first_char;
                                n_head       = slot_dec(r_head);
                                n_count      = r_count + 1'b1;
                                n_res.length = r_count + 1'b1;
                            end
                        end
                        CMD_APPEND: begin
                            if (full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                o_ram.we     = 1'b1;
                                o_ram.waddr  = slot_add(r_head, r_count);
                                o_ram.wdata  = i_first_char;
                                n_count      = r_count + 1'b1;
                                n_res.length = r_count + 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        CMD_CLEAR: begin
                            n_res.removed = r_count;
                            n_res.length  = '0;
                            n_count       = '0;
                            n_head        = '0;
                        end
                        CMD_FIND: begin
                            if (r_count == '0) begin
                                n_res.status = STAT_MISS;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Reads run one entry ahead of the check. Writes go to the kept slot,
                // which always trails every slot still to be read.
                rd_issue = (r_rd_idx != r_count);
                if (rd_issue) begin
                    n_rd_idx    = r_rd_idx + 1'b1;
                    n_rd_slot   = slot_inc(r_rd_slot);
                    n_chk_valid = 1'b1;
                end
                if (r_chk_valid) begin
                    if (r_cmd == CMD_FIND) begin
                        if (i_rd_data == r_a || i_rd_data == r_b) begin
                            // The entry under check sits at 1-based position r_rd_idx.
                            n_res.status   = STAT_OK;
                            n_res.position = r_rd_idx;
                            n_chk_valid    = 1'b0;
                            n_state        = ST_DONE;
                        end else if (r_rd_idx == r_count && !rd_issue) begin
                            n_res.status = STAT_MISS;
                            n_state      = ST_DONE;
                        end
                    end else begin
                        if (i_rd_data != r_a) begin
                            o_ram.we    = 1'b1;
                            kept_next   = r_kept + 1'b1;
                            n_kept_slot = slot_inc(r_kept_slot);
                        end
                        n_kept = kept_next;
                        if (!rd_issue) begin
                            n_count       = kept_next;
                            n_res.removed = r_count - kept_next;
                            n_res.length  = kept_next;
                            n_state       = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_a         <= n_a;
        r_b         <= n_b;
        r_rd_idx    <= n_rd_idx;
        r_rd_slot   <= n_rd_slot;
        r_kept      <= n_kept;
        r_kept_slot <= n_kept_slot;
        r_res       <= n_res;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_chk_valid <= n_chk_valid;
        end
    end

    `CSQ_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `CSQ_ASSERT_IMP(a_wr_when, o_ram.we, r_state == ST_SCAN || (r_state == ST_IDLE && i_valid))
    `CSQ_ASSERT_IMP(a_wr_rd_apart, o_ram.we && rd_issue, o_ram.waddr != o_ram.raddr)
    `CSQ_ASSERT_IMP(a_kept_behind, r_state == ST_SCAN, r_kept <= r_rd_idx)
    `CSQ_ASSERT_NEXT(a_done_holds, r_state == ST_DONE && !i_res_take,
                     r_state == ST_DONE && $stable(r_res))

endmodule
`default_nettype wire
